// ===== design/issbc_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU sample scale and bias calibration package
// Shared constants, scale tables and controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none

package issbc_pkg;

  // Fixed-point formats
  localparam int RESULT_FRAC_BITS = 16;
  localparam int SCALE_FRAC_BITS  = 32;
  localparam int TABLE_FRAC_BITS  = 40;
  localparam int BIAS_FRAC_BITS   = 16;
  localparam int SCALE_SHIFT      = TABLE_FRAC_BITS - SCALE_FRAC_BITS;

  // Datapath widths
  localparam int RAW_W   = 16;
  localparam int SUM_W   = 33;
  localparam int DIFF_W  = SUM_W + 1;
  localparam int MAG_W   = 33;
  localparam int SCALE_W = 25;
  localparam int PROD_W  = MAG_W + SCALE_W;
  localparam int OUT_W   = 25;
  localparam int CNT_W   = 16;
  localparam int NUM_W   = 32 + BIAS_FRAC_BITS;
  localparam int DIV_STEPS = NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Output rounding shifts
  localparam int ACCEL_SHIFT = SCALE_FRAC_BITS - RESULT_FRAC_BITS;
  localparam int GYRO_SHIFT  = BIAS_FRAC_BITS + SCALE_FRAC_BITS - RESULT_FRAC_BITS;
  localparam logic [PROD_W:0] ACCEL_RND = (PROD_W + 1)'(64'd1 << (ACCEL_SHIFT - 1));
  localparam logic [PROD_W:0] GYRO_RND  = (PROD_W + 1)'(64'd1 << (GYRO_SHIFT - 1));

  // Saturation bounds (magnitudes)
  localparam logic [PROD_W:0] OUT_MAX_POS = (PROD_W + 1)'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [PROD_W:0] OUT_MAX_NEG = (PROD_W + 1)'(64'd1 << (OUT_W - 1));

  // Register indexes
  localparam logic [1:0] REG_ACCEL_RANGE = 2'd0;
  localparam logic [1:0] REG_GYRO_RANGE  = 2'd1;
  localparam logic [1:0] REG_CALIB_COUNT = 2'd2;

  // Frame source codes
  localparam logic MODE_ACCEL = 1'b0;
  localparam logic MODE_GYRO  = 1'b1;

  // Register reset values
  localparam logic [1:0]       ACCEL_RANGE_RST = 2'd3;
  localparam logic [2:0]       GYRO_RANGE_RST  = 3'd4;
  localparam logic [2:0]       GYRO_RANGE_MAX  = 3'd4;
  localparam logic [CNT_W-1:0] CALIB_COUNT_RST = '0;

  // Scale tables with 40 fractional bits
  // accel: g * 9.80665 / 32768 for 3, 6, 12, 24 g
  localparam logic [TABLE_FRAC_BITS-1:0] ACCEL_TBL [4] = '{
    40'd987169712, 40'd1974339423, 40'd3948678847, 40'd7897357694
  };
  // gyro: dps * pi / 180 / 32768 for 125 .. 2000 deg/s
  localparam logic [TABLE_FRAC_BITS-1:0] GYRO_TBL [5] = '{
    40'd73204415, 40'd146408829, 40'd292817659, 40'd585635317, 40'd1171270634
  };

  // Round a table entry to the scale format, ties up
  function automatic logic [SCALE_W-1:0] scale_round(input logic [TABLE_FRAC_BITS-1:0] t);
    logic [TABLE_FRAC_BITS:0] s;
    s = {1'b0, t} + (TABLE_FRAC_BITS + 1)'(64'd1 << (SCALE_SHIFT - 1));
    return SCALE_W'(s >> SCALE_SHIFT);
  endfunction

  // Controller commands to the datapath
  typedef struct packed {
    logic       latch;
    logic       acc;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic       mag;
    logic       mul;
    logic       fin;
    logic       out_load;
    logic [1:0] axis;
  } issbc_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic gyro;
    logic calib_active;
    logic calib_last;
  } issbc_sts_t;

endpackage

`default_nettype wire

// ===== design/issbc_if.sv =====
// ----------------------------------------------------------------------------
// IMU sample scale and bias calibration channel interfaces
// Valid/ready channels for raw frames in and scaled results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface issbc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] x_low_byte;
  logic [7:0] x_high_byte;
  logic [7:0] y_low_byte;
  logic [7:0] y_high_byte;
  logic [7:0] z_low_byte;
  logic [7:0] z_high_byte;

  modport source (
    output valid, mode, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
           z_low_byte, z_high_byte,
    input  ready
  );
  modport sink (
    input  valid, mode, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
           z_low_byte, z_high_byte,
    output ready
  );
endinterface

interface issbc_out_if;
  logic               valid;
  logic               ready;
  logic               source_kind;
  logic signed [24:0] x_value;
  logic signed [24:0] y_value;
  logic signed [24:0] z_value;

  modport source (
    output valid, source_kind, x_value, y_value, z_value,
    input  ready
  );
  modport sink (
    input  valid, source_kind, x_value, y_value, z_value,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/imu_sample_scale_bias_calibrate.sv =====
// Sequence: a result frame is latched, sorted, scaled axis by axis (magnitude, product,
// rounded result) and loaded into the output word; a calibration frame is latched, sorted and
// accumulated, and the last one then runs the bit-serial bias divider (48 steps per axis, three
// axes in turn). One frame is in work at a time: a new frame waits until the last is done.
// Reset (rst_n low, synchronous): ranges go to 24 g and 2000 deg/s, calibration count,
// frame count, sums and biases to zero; no output word is pending.
// ----------------------------------------------------------------------------
// IMU sample scale and bias calibration top level
// Scales accelerometer and gyroscope frames to Q16 with gyro bias removal.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_sample_scale_bias_calibrate
  import issbc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CNT_W-1:0] cfg_data,
  issbc_in_if.sink              in_ch,
  issbc_out_if.source           out_ch
);

  issbc_cmd_t cmd;
  issbc_sts_t sts;

  // Sequence each frame
  issbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and state
  issbc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_mode         (in_ch.mode),
    .in_x_low_byte   (in_ch.x_low_byte),
    .in_x_high_byte  (in_ch.x_high_byte),
    .in_y_low_byte   (in_ch.y_low_byte),
    .in_y_high_byte  (in_ch.y_high_byte),
    .in_z_low_byte   (in_ch.z_low_byte),
    .in_z_high_byte  (in_ch.z_high_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_source_kind (out_ch.source_kind),
    .out_x_value     (out_ch.x_value),
    .out_y_value     (out_ch.y_value),
    .out_z_value     (out_ch.z_value)
  );

endmodule

`default_nettype wire

// ===== design/issbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// IMU sample scale and bias calibration controller
// Sequences frame intake, bias accumulation, bias division and scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module issbc_ctrl
  import issbc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire issbc_sts_t sts,
  output issbc_cmd_t      cmd
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_SORT      = 10'b0000000010,
    S_ACC       = 10'b0000000100,
    S_DIV_LOAD  = 10'b0000001000,
    S_DIV_STEP  = 10'b0000010000,
    S_DIV_STORE = 10'b0000100000,
    S_MAG       = 10'b0001000000,
    S_MUL       = 10'b0010000000,
    S_FIN       = 10'b0100000000,
    S_OUT       = 10'b1000000000
  } state_t;

  localparam logic [1:0]           AXIS_LAST = 2'd2;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(DIV_STEPS - 1);

  state_t               state_r, state_nxt;
  logic [1:0]           axis_r, axis_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    axis_nxt    = axis_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    cmd.axis    = axis_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_SORT;
        end
      end
      S_SORT: begin
        axis_nxt = '0;
        if (sts.gyro && sts.calib_active) begin
          state_nxt = S_ACC;
        end else begin
          state_nxt = S_MAG;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.calib_last) begin
          state_nxt = S_DIV_LOAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        div_cnt_nxt  = '0;
        state_nxt    = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = S_DIV_STORE;
        end
      end
      S_DIV_STORE: begin
        cmd.div_store = 1'b1;
        if (axis_r == AXIS_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_DIV_LOAD;
        end
      end
      S_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (axis_r == AXIS_LAST) begin
          state_nxt = S_OUT;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_MAG;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the output word until the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/issbc_dp.sv =====
// ----------------------------------------------------------------------------
// IMU sample scale and bias calibration datapath
// Config registers, bias sums, bit-serial bias divider, scaling multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module issbc_dp
  import issbc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CNT_W-1:0]    cfg_data,
  input  wire logic                in_mode,
  input  wire logic [7:0]          in_x_low_byte,
  input  wire logic [7:0]          in_x_high_byte,
  input  wire logic [7:0]          in_y_low_byte,
  input  wire logic [7:0]          in_y_high_byte,
  input  wire logic [7:0]          in_z_low_byte,
  input  wire logic [7:0]          in_z_high_byte,
  input  wire issbc_cmd_t          cmd,
  output issbc_sts_t               sts,
  output logic                     out_source_kind,
  output logic signed [OUT_W-1:0]  out_x_value,
  output logic signed [OUT_W-1:0]  out_y_value,
  output logic signed [OUT_W-1:0]  out_z_value
);

  // Configuration
  logic [1:0]       accel_sel_r;
  logic [2:0]       gyro_sel_r;
  logic [CNT_W-1:0] calib_cnt_r;

  // Calibration state
  logic [CNT_W-1:0]        fc_r;
  logic signed [SUM_W-1:0] sum_r  [3];
  logic signed [SUM_W-1:0] bias_r [3];

  // Frame and working registers
  logic                    mode_r;
  logic signed [RAW_W-1:0] raw_r [3];
  logic [NUM_W-1:0]        div_q_r;
  logic [CNT_W-1:0]        div_rem_r;
  logic                    div_neg_r;
  logic [MAG_W-1:0]        mag_r;
  logic                    neg_r;
  logic [PROD_W-1:0]       prod_r;
  logic signed [OUT_W-1:0] res_r [3];
  logic                    out_kind_r;
  logic signed [OUT_W-1:0] out_x_r, out_y_r, out_z_r;

  // Combinational helpers
  logic signed [SUM_W-1:0]  sum_sel;
  logic [SUM_W-1:0]         sum_abs;
  logic [NUM_W-1:0]         div_num;
  logic [CNT_W:0]           div_trial;
  logic                     div_ge;
  logic [CNT_W:0]           div_diff;
  logic [SUM_W-1:0]         quo;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_abs;
  logic [2:0]               gyro_sel;
  logic [SCALE_W-1:0]       scale;
  logic [PROD_W:0]          rnd_sum;
  logic [PROD_W:0]          rnd_q;
  logic [OUT_W-1:0]         sat_mag;
  logic signed [OUT_W-1:0]  res_nxt;

  assign sts.gyro         = (mode_r == MODE_GYRO);
  assign sts.calib_active = (fc_r < calib_cnt_r);
  assign sts.calib_last   = ({1'b0, fc_r} + 1'b1) == {1'b0, calib_cnt_r};

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_sel_r <= ACCEL_RANGE_RST;
      gyro_sel_r  <= GYRO_RANGE_RST;
      calib_cnt_r <= CALIB_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACCEL_RANGE: accel_sel_r <= cfg_data[1:0];
        REG_GYRO_RANGE:  gyro_sel_r  <= cfg_data[2:0];
        REG_CALIB_COUNT: calib_cnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Latch the frame and form the signed axes
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r   <= in_mode;
      raw_r[0] <= {in_x_high_byte, in_x_low_byte};
      raw_r[1] <= {in_y_high_byte, in_y_low_byte};
      raw_r[2] <= {in_z_high_byte, in_z_low_byte};
    end
  end

  // Divider numerator: |sum| in Q16 plus half the count for rounding
  assign sum_sel = sum_r[cmd.axis];
  assign sum_abs = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
  assign div_num = {sum_abs[31:0], {BIAS_FRAC_BITS{1'b0}}} + NUM_W'(fc_r >> 1);

  // One restoring division step per cycle
  assign div_trial = {div_rem_r, div_q_r[NUM_W-1]};
  assign div_ge    = (div_trial >= {1'b0, fc_r});
  assign div_diff  = div_trial - {1'b0, fc_r};
  assign quo       = div_q_r[SUM_W-1:0];

  // Accumulate sums and run the bias division
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i]  <= '0;
        bias_r[i] <= '0;
      end
    end else begin
      if (cmd.acc) begin
        fc_r <= fc_r + 1'b1;
        for (int i = 0; i < 3; i++) begin
          sum_r[i] <= sum_r[i] + SUM_W'(raw_r[i]);
        end
      end
      if (cmd.div_store) begin
        bias_r[cmd.axis] <= div_neg_r ? SUM_W'(-quo) : quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_q_r   <= div_num;
      div_rem_r <= '0;
      div_neg_r <= sum_sel[SUM_W-1];
    end else if (cmd.div_step) begin
      div_q_r   <= {div_q_r[NUM_W-2:0], div_ge};
      div_rem_r <= div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
    end
  end

  // Sign and magnitude of the value to scale
  always_comb begin
    if (mode_r == MODE_GYRO) begin
      diff = DIFF_W'($signed({raw_r[cmd.axis], {BIAS_FRAC_BITS{1'b0}}}))
             - DIFF_W'(bias_r[cmd.axis]);
    end else begin
      diff = DIFF_W'(raw_r[cmd.axis]);
    end
    diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  end

  // Pick the scale for the frame source
  assign gyro_sel = (gyro_sel_r > GYRO_RANGE_MAX) ? GYRO_RANGE_MAX : gyro_sel_r;
  assign scale    = (mode_r == MODE_GYRO) ? scale_round(GYRO_TBL[gyro_sel])
                                          : scale_round(ACCEL_TBL[accel_sel_r]);

  // Round to nearest (ties away from zero on the magnitude) and saturate
  always_comb begin
    if (mode_r == MODE_GYRO) begin
      rnd_sum = {1'b0, prod_r} + GYRO_RND;
      rnd_q   = rnd_sum >> GYRO_SHIFT;
    end else begin
      rnd_sum = {1'b0, prod_r} + ACCEL_RND;
      rnd_q   = rnd_sum >> ACCEL_SHIFT;
    end
    if (neg_r) begin
      sat_mag = (rnd_q > OUT_MAX_NEG) ? OUT_W'(OUT_MAX_NEG) : rnd_q[OUT_W-1:0];
      res_nxt = OUT_W'(-sat_mag);
    end else begin
      sat_mag = (rnd_q > OUT_MAX_POS) ? OUT_W'(OUT_MAX_POS) : rnd_q[OUT_W-1:0];
      res_nxt = sat_mag;
    end
  end

  // Scaling pipeline: magnitude, product, rounded result
  always_ff @(posedge clk) begin
    if (cmd.mag) begin
      mag_r <= diff_abs[MAG_W-1:0];
      neg_r <= diff[DIFF_W-1];
    end
    if (cmd.mul) begin
      prod_r <= mag_r * scale;
    end
    if (cmd.fin) begin
      res_r[cmd.axis] <= res_nxt;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r <= mode_r;
      out_x_r    <= res_r[0];
      out_y_r    <= res_r[1];
      out_z_r    <= res_r[2];
    end
  end

  assign out_source_kind = out_kind_r;
  assign out_x_value     = out_x_r;
  assign out_y_value     = out_y_r;
  assign out_z_value     = out_z_r;

endmodule

`default_nettype wire

// ===== tb/imu_sample_scale_bias_calibrate_test.sv =====
// ----------------------------------------------------------------------------
// IMU sample scale and bias calibration testbench
// Drives raw accelerometer and gyroscope frames through the valid/ready input,
// rewrites the range and calibration registers between phases, and checks
// every output word against a cycle-free model of the scaling and gyro bias
// calibration. A short directed table comes first, then random phases with
// varied sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_sample_scale_bias_calibrate_test;
  import issbc_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 160;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 5000;
  localparam int PHASES        = 16;
  localparam int PHASE_ITEMS   = 120;
  localparam int ACCEL_OUT_SHIFT = 16;
  localparam int GYRO_OUT_SHIFT  = 32;
  localparam int Q40_TO_Q32      = 8;
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Scale steps with 40 fractional bits: g * 9.80665 / 32768 and dps * pi / 180 / 32768
  localparam logic [39:0] ACCEL_STEP_Q40 [4] = '{
    40'd987169712, 40'd1974339423, 40'd3948678847, 40'd7897357694
  };
  localparam logic [39:0] GYRO_STEP_Q40 [5] = '{
    40'd73204415, 40'd146408829, 40'd292817659, 40'd585635317, 40'd1171270634
  };

  typedef struct packed {
    logic        mode;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } frame_t;

  typedef struct packed {
    logic            kind;
    logic [2:0][24:0] val;
  } result_t;

  typedef enum logic {ACT_FRAME, ACT_WRITE} plan_act_t;

  typedef struct packed {
    plan_act_t   act;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    frame_t      frame;
    logic        typed;
    result_t     want;
  } plan_row_t;

  localparam frame_t  NO_FRAME   = '0;
  localparam result_t UNTYPED    = '0;
  localparam result_t ACCEL_ZERO = '{MODE_ACCEL, '0};
  localparam result_t GYRO_ZERO  = '{MODE_GYRO, '0};

  // Directed table: extremes, the smallest and largest range steps, and the calibration corner cases
  localparam plan_row_t DIRECTED_PLAN [32] = '{
    // straight after reset: zero frames give zero words
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_ACCEL, 16'h0000, 16'h0000, 16'h0000}, 1'b1, ACCEL_ZERO},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_GYRO, 16'h0000, 16'h0000, 16'h0000}, 1'b1, GYRO_ZERO},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_ACCEL, 16'h7FFF, 16'h8000, 16'h0001}, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_ACCEL, 16'hFFFF, 16'h7FFE, 16'h8001}, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_GYRO, 16'h7FFF, 16'h8000, 16'hFFFF}, 1'b0, UNTYPED},
    // smallest accel range, then back to the largest
    '{ACT_WRITE, REG_ACCEL_RANGE, 16'd0, NO_FRAME, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_ACCEL, 16'h7FFF, 16'h8000, 16'hFFFF}, 1'b0, UNTYPED},
    '{ACT_WRITE, REG_ACCEL_RANGE, 16'd3, NO_FRAME, 1'b0, UNTYPED},
    // smallest gyro range, and an out-of-table code that acts as 2000 dps
    '{ACT_WRITE, REG_GYRO_RANGE, 16'd0, NO_FRAME, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_GYRO, 16'h7FFF, 16'h8000, 16'h0001}, 1'b0, UNTYPED},
    '{ACT_WRITE, REG_GYRO_RANGE, 16'd7, NO_FRAME, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_GYRO, 16'h8000, 16'h7FFF, 16'hFFFF}, 1'b0, UNTYPED},
    '{ACT_WRITE, REG_GYRO_RANGE, 16'd4, NO_FRAME, 1'b0, UNTYPED},
    // write to the unused index must change nothing
    '{ACT_WRITE, REG_SPARE, 16'hFFFF, NO_FRAME, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_ACCEL, 16'h0001, 16'hFFFF, 16'h4000}, 1'b0, UNTYPED},
    // three-frame calibration, with an accel word ahead of it
    '{ACT_WRITE, REG_CALIB_COUNT, 16'd3, NO_FRAME, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_ACCEL, 16'h1234, 16'hEDCC, 16'h0100}, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_GYRO, 16'h0100, 16'hFF00, 16'h7FFF}, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_GYRO, 16'h0101, 16'hFF01, 16'h7FFF}, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_GYRO, 16'h0102, 16'hFF05, 16'h7FFE}, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_GYRO, 16'h0100, 16'hFF00, 16'h7FFF}, 1'b0, UNTYPED},
    // lower count ends calibration and keeps the bias
    '{ACT_WRITE, REG_CALIB_COUNT, 16'd2, NO_FRAME, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_GYRO, 16'h8000, 16'h7FFF, 16'h0000}, 1'b0, UNTYPED},
    // higher count resumes on the old sums
    '{ACT_WRITE, REG_CALIB_COUNT, 16'd5, NO_FRAME, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_GYRO, 16'hFFFF, 16'h8000, 16'h0003}, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_GYRO, 16'h0001, 16'h8000, 16'hFFFD}, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_GYRO, 16'h0000, 16'h0000, 16'h0000}, 1'b0, UNTYPED},
    // full-scale count, then zero to stop with the bias kept
    '{ACT_WRITE, REG_CALIB_COUNT, 16'hFFFF, NO_FRAME, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_GYRO, 16'h8000, 16'h8000, 16'h8000}, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_ACCEL, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, UNTYPED},
    '{ACT_WRITE, REG_CALIB_COUNT, 16'd0, NO_FRAME, 1'b0, UNTYPED},
    '{ACT_FRAME, REG_ACCEL_RANGE, 16'd0,
      '{MODE_GYRO, 16'h7FFF, 16'h8000, 16'h0000}, 1'b0, UNTYPED}
  };

  string AXIS_NAMES [3] = '{"x_value", "y_value", "z_value"};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [CNT_W-1:0] cfg_data;

  issbc_in_if  in_ch ();
  issbc_out_if out_ch ();

  imu_sample_scale_bias_calibrate uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #CLK_HALF clk = ~clk;

  // Model copy of registers and calibration state
  logic [1:0]         accel_sel;
  logic [2:0]         gyro_sel;
  logic [15:0]        calib_target;
  logic [15:0]        gyro_frames_taken;
  logic signed [32:0] raw_sum [3];
  logic signed [32:0] bias_q16 [3];

  result_t results_due [$];
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holds_asked    = 0;
  int error_count    = 0;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Round the 40-bit table step to 32 fractional bits, ties up
  function automatic logic [63:0] q40_to_q32(input logic [39:0] t);
    return ({24'd0, t} + (64'd1 << (Q40_TO_Q32 - 1))) >> Q40_TO_Q32;
  endfunction

  // Scale a magnitude, round ties away from zero, clamp to 25 bits
  function automatic logic [24:0] round_clamp(input logic neg, input logic [63:0] mag,
                                              input logic [63:0] scale, input int shift);
    logic [63:0] r;
    r = (mag * scale + (64'd1 << (shift - 1))) >> shift;
    if (neg) begin
      if (r > 64'd16777216) r = 64'd16777216;
      r = -r;
    end else if (r > 64'd16777215) begin
      r = 64'd16777215;
    end
    return r[24:0];
  endfunction

  // Work out the output word of one frame; advance calibration state
  function automatic bit scale_frame(input frame_t f, output result_t r);
    logic signed [15:0] raw [3];
    logic [63:0] scale;
    logic [63:0] mag;
    logic [63:0] q;
    logic [2:0]  g;
    longint      d;
    int          k;
    raw[0] = f.x;
    raw[1] = f.y;
    raw[2] = f.z;
    r = '0;
    if (f.mode == MODE_ACCEL) begin
      scale = q40_to_q32(ACCEL_STEP_Q40[accel_sel]);
      r.kind = MODE_ACCEL;
      for (k = 0; k < 3; k++) begin
        d = raw[k];
        mag = (d < 0) ? 64'(-d) : 64'(d);
        r.val[k] = round_clamp(d < 0, mag, scale, ACCEL_OUT_SHIFT);
      end
      return 1'b1;
    end
    // calibration frame: accumulate, set the bias on the last one
    if (gyro_frames_taken < calib_target) begin
      for (k = 0; k < 3; k++) raw_sum[k] = raw_sum[k] + raw[k];
      gyro_frames_taken = gyro_frames_taken + 16'd1;
      if (gyro_frames_taken == calib_target) begin
        for (k = 0; k < 3; k++) begin
          d = raw_sum[k];
          mag = (d < 0) ? 64'(-d) : 64'(d);
          q = ((mag << 16) + 64'(gyro_frames_taken / 16'd2)) / 64'(gyro_frames_taken);
          bias_q16[k] = (d < 0) ? 33'(-longint'(q)) : 33'(q);
        end
      end
      return 1'b0;
    end
    g = (gyro_sel > 3'd4) ? 3'd4 : gyro_sel;
    scale = q40_to_q32(GYRO_STEP_Q40[g]);
    r.kind = MODE_GYRO;
    for (k = 0; k < 3; k++) begin
      d = longint'(raw[k]) * 65536 - longint'(bias_q16[k]);
      mag = (d < 0) ? 64'(-d) : 64'(d);
      r.val[k] = round_clamp(d < 0, mag, scale, GYRO_OUT_SHIFT);
    end
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(11))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one frame word, with random idle cycles ahead of it
  task automatic offer_frame(input frame_t f, input logic typed, input result_t want);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= f.mode;
    in_ch.x_low_byte  <= f.x[7:0];
    in_ch.x_high_byte <= f.x[15:8];
    in_ch.y_low_byte  <= f.y[7:0];
    in_ch.y_high_byte <= f.y[15:8];
    in_ch.z_low_byte  <= f.z[7:0];
    in_ch.z_high_byte <= f.z[15:8];
    do @(posedge clk); while (!in_ch.ready);
    if (scale_frame(f, r)) begin
      if (typed) r = want;
      results_due.push_back(r);
    end
  endtask

  // Hold the input idle until every expected word has arrived
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  // Drain, then let a trailing calibration frame finish its divide
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_config(input logic [1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_ACCEL_RANGE: accel_sel    = value[1:0];
      REG_GYRO_RANGE:  gyro_sel     = value[2:0];
      REG_CALIB_COUNT: calib_target = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off when asked
  initial begin : result_taker
    int hold_left;
    int holds_taken;
    hold_left = 0;
    holds_taken = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_taken != holds_asked) begin
        holds_taken = holds_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each output word with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    int k;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.kind = out_ch.source_kind;
      got.val  = {out_ch.z_value, out_ch.y_value, out_ch.x_value};
      if (results_due.size() == 0) begin
        report($sformatf("word with none expected, x_value %0d", $signed(got.val[0])));
      end else begin
        want = results_due.pop_front();
        if (got.kind !== want.kind)
          report($sformatf("source_kind got %0b expected %0b", got.kind, want.kind));
        for (k = 0; k < 3; k++) begin
          if (got.val[k] !== want.val[k])
            report($sformatf("%s got %0d expected %0d", AXIS_NAMES[k],
                             $signed(got.val[k]), $signed(want.val[k])));
        end
      end
    end
  end

  // Watchdog: end the run after too long without any word moving
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int row;
    int phase;
    int item;
    int target;
    frame_t f;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_ACCEL_RANGE;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_ACCEL;
    in_ch.x_low_byte  <= '0;
    in_ch.x_high_byte <= '0;
    in_ch.y_low_byte  <= '0;
    in_ch.y_high_byte <= '0;
    in_ch.z_low_byte  <= '0;
    in_ch.z_high_byte <= '0;
    // reset view: 24 g, 2000 dps, no calibration
    accel_sel         = 2'd3;
    gyro_sel          = 3'd4;
    calib_target      = '0;
    gyro_frames_taken = '0;
    raw_sum           = '{default: '0};
    bias_q16          = '{default: '0};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (row = 0; row < $size(DIRECTED_PLAN); row++) begin
      if (DIRECTED_PLAN[row].act == ACT_WRITE) begin
        settle();
        put_config(DIRECTED_PLAN[row].reg_idx, DIRECTED_PLAN[row].reg_val);
      end else begin
        offer_frame(DIRECTED_PLAN[row].frame, DIRECTED_PLAN[row].typed,
                    DIRECTED_PLAN[row].want);
      end
    end

    // Random phases: new settings each time, idling pattern cycling
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      put_config(REG_ACCEL_RANGE, 16'($urandom_range(3)));
      put_config(REG_GYRO_RANGE, 16'($urandom_range(7)));
      case ($urandom_range(3))
        0: target = 0;
        1: target = $urandom_range(int'(gyro_frames_taken));
        default: begin
          target = int'(gyro_frames_taken) + int'($urandom_range(10, 1));
          if (target > 65535) target = 65535;
        end
      endcase
      put_config(REG_CALIB_COUNT, 16'(target));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (item = 0; item < PHASE_ITEMS; item++) begin
        // long receiver hold-off while frames keep coming; later a full pause
        if (phase == 0 && item == 10) holds_asked++;
        if (phase == 1 && item == 60) drain_results();
        f.mode = 1'($urandom_range(1));
        f.x = pick_axis();
        f.y = pick_axis();
        f.z = pick_axis();
        offer_frame(f, 1'b0, UNTYPED);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/issbc_pkg.sv
design/issbc_if.sv
design/issbc_ctrl.sv
design/issbc_dp.sv
design/imu_sample_scale_bias_calibrate.sv
tb/imu_sample_scale_bias_calibrate_test.sv
